### rtl/core/gnf_pkg.sv
// Shared package for the fractal gradient noise block: field widths, codes,
// the controller-to-datapath command and status structs and the gradient ROM.
// Depends on nothing; gnf_ctrl, gnf_datapath and the top level use it by scoped names.
`default_nettype none

package gnf_pkg;

   // Default parameter values.
   localparam int TABLE_SIZE_DEF  = 256;
   localparam int MAX_OCTAVES_DEF = 8;

   // Fixed field widths.
   localparam int COORD_W      = 16;
   localparam int FRAC_W       = 16;
   localparam int PERM_W       = 8;
   localparam int GRAD_W       = 16;
   localparam int CORNER_W     = 34;
   localparam int WEIGHT_W     = 17;
   localparam int OCT_CFG_W    = 4;
   localparam int FREQ_CFG_W   = 16;
   localparam int NOISE_OUT_W  = 16;
   localparam int BYTE_W       = 8;
   localparam int DEN_SHIFT    = 15;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 16;

   // Command codes of the input channel.
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_OCTAVE_COUNT   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_FREQUENCY = 1'b1;

   // Strobes from the controller, at most one high in any cycle.
   typedef struct packed {
      logic load_wr;
      logic start;
      logic pos;
      logic rd0;
      logic rd1;
      logic rd2;
      logic rd3;
      logic lerp1;
      logic lerp2;
      logic acc;
      logic div_init;
      logic div_step;
      logic out_load;
   } gnf_cmd_type;

   typedef struct packed {
      logic last_octave;
      logic div_last;
      logic rsp_busy;
   } gnf_status_type;

   typedef logic signed [GRAD_W-1:0] grad_rom_type [256];

   localparam longint unsigned PI_Q28 = 64'd843314857;

   // Taylor series divisors: (2n-1)(2n) for the cosine terms and (2n)(2n+1)
   // for the sine terms, n = 1 to 14.
   localparam longint unsigned COS_DIV [14] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
      64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756
   };
   localparam longint unsigned SIN_DIV [14] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
      64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
   };

   // Gradient table in Q1.14, built at elaboration with an integer Taylor
   // series in Q28 and rounded half away from zero. sel_sin picks the sine.
   function automatic grad_rom_type build_grad_rom(input logic sel_sin);
      grad_rom_type     rom;
      longint unsigned  k;
      longint unsigned  a;
      longint unsigned  a2;
      longint unsigned  tc;
      longint unsigned  ts;
      longint           c;
      longint           s;
      longint           v;
      longint           r;
      for (int p = 0; p < 256; p++) begin
         k  = (p < 128) ? longint'(p) : longint'(255 - p);
         a  = (64'd2 * PI_Q28 * k) / 64'd255;
         a2 = (a * a) >> 28;
         tc = 64'd1 << 28;
         ts = a;
         c  = longint'(tc);
         s  = longint'(ts);
         for (int n = 1; n <= 14; n++) begin
            tc = ((tc * a2) >> 28) / COS_DIV[n - 1];
            ts = ((ts * a2) >> 28) / SIN_DIV[n - 1];
            if ((n % 2) == 1) begin
               c = c - longint'(tc);
               s = s - longint'(ts);
            end else begin
               c = c + longint'(tc);
               s = s + longint'(ts);
            end
         end
         if (p >= 128) begin
            s = -s;
         end
         v = sel_sin ? s : c;
         if (v >= 0) begin
            r = (v + 8192) >>> 14;
         end else begin
            r = -((-v + 8192) >>> 14);
         end
         rom[p] = GRAD_W'(r);
      end
      return rom;
   endfunction

   localparam grad_rom_type GRAD_COS = build_grad_rom(1'b0);
   localparam grad_rom_type GRAD_SIN = build_grad_rom(1'b1);

endpackage

`default_nettype wire

### rtl/core/gnf_ram.sv
// Generic memory: one write port and two read ports with registered data.
// Depends on nothing.
`default_nettype none

module gnf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

`default_nettype wire

### rtl/core/gnf_ctrl.sv
// Sequencer for the fractal noise block: walks each octave through its steps,
// then the divider, then hands the result to the output register.
// Depends on gnf_pkg.
`default_nettype none

module gnf_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_command,
   output logic                        req_ready,
   input  wire gnf_pkg::gnf_status_type status,
   output gnf_pkg::gnf_cmd_type        cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_POS, ST_RD0, ST_RD1, ST_RD2, ST_RD3,
      ST_LERP1, ST_LERP2, ST_ACC, ST_DIV_INIT, ST_DIV, ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == gnf_pkg::CMD_EVAL) begin
                  cmd.start = 1'b1;
                  state_in  = ST_POS;
               end else begin
                  cmd.load_wr = 1'b1;
               end
            end
         end
         ST_POS: begin
            cmd.pos  = 1'b1;
            state_in = ST_RD0;
         end
         ST_RD0: begin
            cmd.rd0  = 1'b1;
            state_in = ST_RD1;
         end
         ST_RD1: begin
            cmd.rd1  = 1'b1;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            cmd.rd2  = 1'b1;
            state_in = ST_RD3;
         end
         ST_RD3: begin
            cmd.rd3  = 1'b1;
            state_in = ST_LERP1;
         end
         ST_LERP1: begin
            cmd.lerp1 = 1'b1;
            state_in  = ST_LERP2;
         end
         ST_LERP2: begin
            cmd.lerp2 = 1'b1;
            state_in  = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = status.last_octave ? ST_DIV_INIT : ST_POS;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!status.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/gnf_datapath.sv
// Datapath of the fractal noise block: configuration registers, permutation
// table, per-octave lattice arithmetic, accumulator, divider and output stage.
// Depends on gnf_pkg and gnf_ram.
`default_nettype none

module gnf_datapath #(
   parameter int TABLE_SIZE  = gnf_pkg::TABLE_SIZE_DEF,
   parameter int MAX_OCTAVES = gnf_pkg::MAX_OCTAVES_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire gnf_pkg::gnf_cmd_type                   cmd,
   output gnf_pkg::gnf_status_type                     status,
   input  wire logic                                   csr_valid,
   input  wire logic [gnf_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [gnf_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  wire logic [gnf_pkg::PERM_W-1:0]             req_table_index,
   input  wire logic [gnf_pkg::PERM_W-1:0]             req_table_value,
   input  wire logic [gnf_pkg::COORD_W-1:0]            req_coord_x,
   input  wire logic [gnf_pkg::COORD_W-1:0]            req_coord_y,
   input  wire logic                                   rsp_ready,
   output logic                                        rsp_valid,
   output logic signed [gnf_pkg::NOISE_OUT_W-1:0]      rsp_noise_value,
   output logic [gnf_pkg::BYTE_W-1:0]                  rsp_pixel_byte
);

   localparam int IdxW   = $clog2(TABLE_SIZE);
   localparam int SumW   = ((IdxW > gnf_pkg::PERM_W) ? IdxW : gnf_pkg::PERM_W) + 1;
   localparam int OctW   = $clog2(MAX_OCTAVES + 1);
   localparam int FreqW  = gnf_pkg::FREQ_CFG_W + MAX_OCTAVES - 1;
   localparam int PosW   = gnf_pkg::COORD_W + FreqW;
   localparam int FW     = gnf_pkg::FRAC_W;
   localparam int CW     = gnf_pkg::CORNER_W;
   localparam int WW     = gnf_pkg::WEIGHT_W;
   localparam int AccW   = CW + MAX_OCTAVES;
   localparam int NumW   = AccW + 8 - gnf_pkg::DEN_SHIFT;
   localparam int CntW   = $clog2(NumW + 1);
   localparam int DenW   = MAX_OCTAVES;
   localparam int SqW    = 2 * FW;
   localparam int SmW    = FW + 2;
   localparam int SpW    = SqW + SmW;
   localparam int DiffW  = CW + 1;
   localparam int LpW    = DiffW + WW + 1;
   localparam int PW     = gnf_pkg::PERM_W;
   localparam int QW     = gnf_pkg::NOISE_OUT_W;
   localparam int BW     = gnf_pkg::BYTE_W;

   // Configuration.
   logic [gnf_pkg::OCT_CFG_W-1:0]  octave_count_ff;
   logic [gnf_pkg::FREQ_CFG_W-1:0] base_frequency_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff   <= gnf_pkg::OCT_CFG_W'(1);
         base_frequency_ff <= gnf_pkg::FREQ_CFG_W'(256);
      end else if (csr_valid) begin
         case (csr_index)
            gnf_pkg::CSR_OCTAVE_COUNT: begin
               octave_count_ff <= csr_wdata[gnf_pkg::OCT_CFG_W-1:0];
            end
            gnf_pkg::CSR_BASE_FREQUENCY: begin
               base_frequency_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Working registers.
   logic [gnf_pkg::COORD_W-1:0] coord_x_ff, coord_y_ff;
   logic [FreqW-1:0]            freq_ff;
   logic [OctW-1:0]             oct_ff, n_ff;
   logic [PosW-1:0]             px_ff, py_ff;
   logic [SqW-1:0]              sqx_ff, sqy_ff;
   logic [WW-1:0]               u_ff, v_ff;
   logic [PW-1:0]               hx0_ff, hx1_ff;
   logic signed [CW-1:0]        c_aa_ff, c_ba_ff, c_ab_ff, c_bb_ff;
   logic signed [CW-1:0]        bottom_ff, top_ff, noise_ff;
   logic signed [AccW-1:0]      acc_ff;
   logic [NumW-1:0]             numq_ff, numb_ff;
   logic [DenW:0]               remq_ff, remb_ff;
   logic [DenW-1:0]             den_ff;
   logic [CntW-1:0]             cnt_ff;
   logic                        neg_ff;
   logic                        rsp_valid_ff;
   logic signed [QW-1:0]        rsp_noise_ff;
   logic [BW-1:0]               rsp_byte_ff;

   // Lattice cell and fraction of the current octave.
   logic [IdxW-1:0] cx, cy, cx1, cy1;
   logic [FW-1:0]   fx, fy;

   assign cx  = px_ff[FW +: IdxW];
   assign cy  = py_ff[FW +: IdxW];
   assign cx1 = cx + IdxW'(1);
   assign cy1 = cy + IdxW'(1);
   assign fx  = px_ff[FW-1:0];
   assign fy  = py_ff[FW-1:0];

   // Permutation table.
   logic            ram_wr_en;
   logic [IdxW-1:0] ram_addr_a, ram_addr_b;
   logic [PW-1:0]   ram_data_a, ram_data_b;

   assign ram_wr_en = cmd.load_wr && (32'(req_table_index) < 32'(TABLE_SIZE));

   function automatic logic [IdxW-1:0] hash_addr(input logic [PW-1:0] h,
                                                 input logic [IdxW-1:0] c);
      return IdxW'(SumW'(h) + SumW'(c));
   endfunction

   always_comb begin
      ram_addr_a = cx;
      ram_addr_b = cx1;
      if (cmd.rd1) begin
         ram_addr_a = hash_addr(ram_data_a, cy);
         ram_addr_b = hash_addr(ram_data_b, cy);
      end else if (cmd.rd2) begin
         ram_addr_a = hash_addr(hx0_ff, cy1);
         ram_addr_b = hash_addr(hx1_ff, cy1);
      end
   end

   gnf_ram #(
      .WIDTH (PW),
      .DEPTH (TABLE_SIZE)
   ) u_perm (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (IdxW'(req_table_index)),
      .wr_data   (req_table_value),
      .rd_addr_a (ram_addr_a),
      .rd_data_a (ram_data_a),
      .rd_addr_b (ram_addr_b),
      .rd_data_b (ram_data_b)
   );

   // Dot product of a corner offset with the gradient of hash value g.
   function automatic logic signed [CW-1:0] corner(input logic [PW-1:0] g,
                                                   input logic signed [FW:0] dx,
                                                   input logic signed [FW:0] dy);
      return CW'(dx) * CW'(gnf_pkg::GRAD_COS[g]) + CW'(dy) * CW'(gnf_pkg::GRAD_SIN[g]);
   endfunction

   // a + floor((b - a) * w / 2^16), equal to floor((a*(2^16-w) + b*w) / 2^16).
   function automatic logic signed [CW-1:0] lerp(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b,
                                                 input logic [WW-1:0] w);
      logic signed [DiffW-1:0] d;
      logic signed [LpW-1:0]   p;
      d = DiffW'(b) - DiffW'(a);
      p = LpW'(d) * LpW'($signed({1'b0, w}));
      return CW'(LpW'(a) + (p >>> FW));
   endfunction

   function automatic logic [WW-1:0] smooth(input logic [SqW-1:0] sq,
                                            input logic [FW-1:0] f);
      logic [SmW-1:0] t;
      logic [SpW-1:0] p;
      t = SmW'(3 * (1 << FW)) - {1'b0, f, 1'b0};
      p = SpW'(sq) * SpW'(t);
      return p[SqW +: WW];
   endfunction

   // Offsets f and f - 1 in Q.16 as 17-bit signed values.
   logic signed [FW:0] dx0, dx1, dy0, dy1;
   assign dx0 = $signed({1'b0, fx});
   assign dx1 = $signed({1'b1, fx});
   assign dy0 = $signed({1'b0, fy});
   assign dy1 = $signed({1'b1, fy});

   // Clamped octave count and divider inputs.
   logic [OctW-1:0]     n_in;
   logic [DenW:0]       pow_n;
   logic [AccW-1:0]     acc_mag;
   logic [AccW+7:0]     acc_x255;
   logic [DenW:0]       remq_sh, remb_sh;

   always_comb begin
      if (octave_count_ff == '0) begin
         n_in = OctW'(1);
      end else if (32'(octave_count_ff) > 32'(MAX_OCTAVES)) begin
         n_in = OctW'(MAX_OCTAVES);
      end else begin
         n_in = OctW'(octave_count_ff);
      end
   end

   assign pow_n    = (DenW+1)'(1) << n_ff;
   assign acc_mag  = acc_ff[AccW-1] ? AccW'(-acc_ff) : AccW'(acc_ff);
   assign acc_x255 = (AccW+8)'(acc_mag) * (AccW+8)'(255);
   assign remq_sh  = {remq_ff[DenW-1:0], numq_ff[NumW-1]};
   assign remb_sh  = {remb_ff[DenW-1:0], numb_ff[NumW-1]};

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         coord_x_ff <= req_coord_x;
         coord_y_ff <= req_coord_y;
         freq_ff    <= FreqW'(base_frequency_ff);
         oct_ff     <= '0;
         n_ff       <= n_in;
         acc_ff     <= '0;
      end
      if (cmd.pos) begin
         px_ff <= PosW'(coord_x_ff) * PosW'(freq_ff);
         py_ff <= PosW'(coord_y_ff) * PosW'(freq_ff);
      end
      if (cmd.rd0) begin
         sqx_ff <= SqW'(fx) * SqW'(fx);
         sqy_ff <= SqW'(fy) * SqW'(fy);
      end
      if (cmd.rd1) begin
         hx0_ff <= ram_data_a;
         hx1_ff <= ram_data_b;
         u_ff   <= smooth(sqx_ff, fx);
         v_ff   <= smooth(sqy_ff, fy);
      end
      if (cmd.rd2) begin
         c_aa_ff <= corner(ram_data_a, dx0, dy0);
         c_ba_ff <= corner(ram_data_b, dx1, dy0);
      end
      if (cmd.rd3) begin
         c_ab_ff <= corner(ram_data_a, dx0, dy1);
         c_bb_ff <= corner(ram_data_b, dx1, dy1);
      end
      if (cmd.lerp1) begin
         bottom_ff <= lerp(c_aa_ff, c_ba_ff, u_ff);
         top_ff    <= lerp(c_ab_ff, c_bb_ff, u_ff);
      end
      if (cmd.lerp2) begin
         noise_ff <= lerp(bottom_ff, top_ff, v_ff);
      end
      if (cmd.acc) begin
         // Horner form: the earliest octave ends with the largest weight.
         acc_ff  <= (acc_ff <<< 1) + AccW'(noise_ff);
         oct_ff  <= oct_ff + OctW'(1);
         freq_ff <= freq_ff << 1;
      end
      if (cmd.div_init) begin
         neg_ff  <= acc_ff[AccW-1];
         numq_ff <= NumW'(acc_mag >> gnf_pkg::DEN_SHIFT);
         numb_ff <= NumW'(acc_x255 >> gnf_pkg::DEN_SHIFT);
         remq_ff <= '0;
         remb_ff <= '0;
         den_ff  <= DenW'(pow_n - (DenW+1)'(1));
         cnt_ff  <= '0;
      end
      if (cmd.div_step) begin
         cnt_ff <= cnt_ff + CntW'(1);
         if (remq_sh >= (DenW+1)'(den_ff)) begin
            remq_ff <= remq_sh - (DenW+1)'(den_ff);
            numq_ff <= {numq_ff[NumW-2:0], 1'b1};
         end else begin
            remq_ff <= remq_sh;
            numq_ff <= {numq_ff[NumW-2:0], 1'b0};
         end
         if (remb_sh >= (DenW+1)'(den_ff)) begin
            remb_ff <= remb_sh - (DenW+1)'(den_ff);
            numb_ff <= {numb_ff[NumW-2:0], 1'b1};
         end else begin
            remb_ff <= remb_sh;
            numb_ff <= {numb_ff[NumW-2:0], 1'b0};
         end
      end
   end

   // Saturation of the quotients, applied when the result is loaded.
   logic signed [QW-1:0] noise_sat;
   logic [BW-1:0]        byte_sat;

   always_comb begin
      if (neg_ff) begin
         if (numq_ff > NumW'(1 << (QW - 1))) begin
            noise_sat = QW'(1 << (QW - 1));
         end else begin
            noise_sat = -$signed(QW'(numq_ff));
         end
         byte_sat = '0;
      end else begin
         if (numq_ff > NumW'((1 << (QW - 1)) - 1)) begin
            noise_sat = QW'((1 << (QW - 1)) - 1);
         end else begin
            noise_sat = $signed(QW'(numq_ff));
         end
         if (numb_ff > NumW'((1 << BW) - 1)) begin
            byte_sat = '1;
         end else begin
            byte_sat = BW'(numb_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_noise_ff <= noise_sat;
         rsp_byte_ff  <= byte_sat;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_ff;
   assign rsp_pixel_byte  = rsp_byte_ff;

   assign status.last_octave = (oct_ff == OctW'(n_ff - OctW'(1)));
   assign status.div_last    = (cnt_ff == CntW'(NumW - 1));
   assign status.rsp_busy    = rsp_valid_ff && !rsp_ready;

endmodule

`default_nettype wire

### rtl/core/gradient_noise_fbm_2d.sv
// Fractal 2D gradient noise, one pixel per evaluate transfer. An evaluate runs N octaves,
// N the clamped octave count, then a divider yielding NumW = MAX_OCTAVES + 27 quotient
// bits (35 by default). Each octave takes eight steps of one shared datapath; the divider
// gives one quotient bit a cycle. A new transfer is taken only after the previous evaluate
// has loaded its result into the output register; loads are accepted back to back.
// Reset clears control state, sets octave_count to 1 and base_frequency to 256 only.
`default_nettype none

// A load transfer writes one permutation entry straight into the table in the
// cycle it is accepted and produces no result. An evaluate transfer makes the
// block busy: the controller steps each octave through lattice position,
// two rounds of table reads for the cell hash, corner dot products and the two
// blends, and folds the octave into the accumulator. A restoring divider then
// normalises the sum, for the Q1.15 value and the byte at once. The result sits
// in an output register, so the next transfer is accepted while it waits.
// The permutation table is not cleared by reset.

module gradient_noise_fbm_2d #(
   parameter int TABLE_SIZE  = gnf_pkg::TABLE_SIZE_DEF,
   parameter int MAX_OCTAVES = gnf_pkg::MAX_OCTAVES_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_command,
   input  wire logic [gnf_pkg::PERM_W-1:0]           req_table_index,
   input  wire logic [gnf_pkg::PERM_W-1:0]           req_table_value,
   input  wire logic [gnf_pkg::COORD_W-1:0]          req_coord_x,
   input  wire logic [gnf_pkg::COORD_W-1:0]          req_coord_y,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [gnf_pkg::NOISE_OUT_W-1:0]    rsp_noise_value,
   output logic [gnf_pkg::BYTE_W-1:0]                rsp_pixel_byte,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [gnf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [gnf_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   gnf_pkg::gnf_cmd_type    ctrl_cmd;
   gnf_pkg::gnf_status_type dp_status;

   // Configuration writes are always taken; an evaluate samples both registers
   // when it is accepted, so a write affects only later evaluates.
   assign csr_ready = 1'b1;

   gnf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .status      (dp_status),
      .cmd         (ctrl_cmd)
   );

   gnf_datapath #(
      .TABLE_SIZE  (TABLE_SIZE),
      .MAX_OCTAVES (MAX_OCTAVES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctrl_cmd),
      .status          (dp_status),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_noise_value (rsp_noise_value),
      .rsp_pixel_byte  (rsp_pixel_byte)
   );

   // The controller never issues two datapath steps in the same cycle.
   assert property (@(posedge clock) disable iff (reset) $onehot0(ctrl_cmd))
      else $error("more than one datapath step issued");

   // An accepted evaluate transfer makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == gnf_pkg::CMD_EVAL) |=> !req_ready)
      else $error("evaluate accepted but input side still ready");

   // A new result only appears after the busy phase of an evaluate.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without an evaluate in flight");

endmodule

`default_nettype wire
